### sv/bcbp_pkg.sv
// ----------------------------------------------------------------------------
// bcbp_pkg
// Shared types and constants of the binary context bit predictor: register
// map of the configuration port and the configuration bundle.
// ----------------------------------------------------------------------------
package bcbp_pkg;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam int ORDER_BITS = 4;
    localparam logic [ORDER_BITS-1:0] ORDER_RESET = 4'd12;

    typedef logic [0:0] t_reg_idx;
    localparam t_reg_idx REG_ORDER_IN_USE = 1'b0;
    localparam t_reg_idx REG_DECODE_MODE  = 1'b1;

    typedef struct packed {
        logic [ORDER_BITS-1:0] order_in_use;
        logic                  decode_mode;
    } t_cfg;

endpackage

### sv/bcbp_if.sv
// ----------------------------------------------------------------------------
// bcbp_in_if / bcbp_out_if
// Valid/ready channels of the predictor: one bit in, one bit out per item.
// ----------------------------------------------------------------------------
interface bcbp_in_if;
    logic valid;
    logic ready;
    logic in_bit;

    modport source (output valid, output in_bit, input ready);
    modport sink   (input valid, input in_bit, output ready);
endinterface

interface bcbp_out_if;
    logic valid;
    logic ready;
    logic out_bit;

    modport source (output valid, output out_bit, input ready);
    modport sink   (input valid, input out_bit, output ready);
endinterface

### sv/bcbp_ram.sv
// ----------------------------------------------------------------------------
// bcbp_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module bcbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/bcbp_cfg.sv
// ----------------------------------------------------------------------------
// bcbp_cfg
// APB register file: order_in_use at byte address 0, decode_mode at 4.
// ----------------------------------------------------------------------------
module bcbp_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bcbp_pkg::APB_AW-1:0]  paddr,
    input  logic [bcbp_pkg::APB_DW-1:0]  pwdata,
    output logic [bcbp_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output bcbp_pkg::t_cfg               o_cfg
);
    import bcbp_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[2:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_ORDER_IN_USE: n_cfg.order_in_use = pwdata[ORDER_BITS-1:0];
                REG_DECODE_MODE:  n_cfg.decode_mode  = pwdata[0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ORDER_IN_USE: prdata = APB_DW'(r_cfg.order_in_use);
            REG_DECODE_MODE:  prdata = APB_DW'(r_cfg.decode_mode);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.order_in_use <= ORDER_RESET;
            r_cfg.decode_mode  <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### sv/bcbp_engine.sv
// ----------------------------------------------------------------------------
// bcbp_engine
// Prediction and learning sequencer around the count RAM. One RAM word holds
// the count pair {count1, count0} of one context of one order. A first pass
// reads orders 0..top and keeps the prediction of the longest order seen with
// data; a second pass reads the same words again and writes the bumped count.
// ----------------------------------------------------------------------------
module bcbp_engine #(
    parameter int MAX_ORDER  = 12,
    parameter int COUNT_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bcbp_pkg::t_cfg i_cfg,
    bcbp_in_if.sink        i_in,
    bcbp_out_if.source     o_out
);
    import bcbp_pkg::*;

    localparam int PW    = MAX_ORDER + 1;
    localparam int DEPTH = (1 << PW) - 1;
    localparam int KW    = $clog2(MAX_ORDER + 2);
    localparam int HW    = (MAX_ORDER > 0) ? MAX_ORDER : 1;
    localparam int DW    = 2 * COUNT_BITS;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PRED  = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;

    logic [2:0]      r_state, n_state;
    logic [KW-1:0]   r_k, n_k;
    logic            r_rv, n_rv;
    logic [PW-1:0]   r_wa, n_wa;
    logic [PW-1:0]   r_clr, n_clr;
    logic            r_pred, n_pred;
    logic            r_in_bit, n_in_bit;
    logic            r_actual, n_actual;
    logic [HW-1:0]   r_hist, n_hist;
    logic            r_out_valid, n_out_valid;
    logic            r_out_bit, n_out_bit;

    logic [KW-1:0]         w_top;
    logic                  w_issue;
    logic [PW-1:0]         w_ones;
    logic [PW-1:0]         w_raddr;
    logic [DW-1:0]         w_rdata;
    logic [COUNT_BITS-1:0] w_c0, w_c1, w_sel, w_inc;
    logic                  w_we;
    logic [PW-1:0]         w_waddr;
    logic [DW-1:0]         w_wdata;

    assign w_top = (int'(i_cfg.order_in_use) > MAX_ORDER) ? KW'(MAX_ORDER)
                                                         : KW'(i_cfg.order_in_use);
    assign w_issue = (r_k <= w_top);
    // low k bits set: base of order k is 2^k - 1, context is the low k history bits
    assign w_ones  = ~({PW{1'b1}} << r_k);
    assign w_raddr = w_ones + (PW'(r_hist) & w_ones);

    assign w_c0  = w_rdata[COUNT_BITS-1:0];
    assign w_c1  = w_rdata[DW-1:COUNT_BITS];
    assign w_sel = r_actual ? w_c1 : w_c0;
    assign w_inc = (w_sel == {COUNT_BITS{1'b1}}) ? w_sel : w_sel + COUNT_BITS'(1);

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.out_bit = r_out_bit;

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_rv        = r_rv;
        n_wa        = r_wa;
        n_clr       = r_clr;
        n_pred      = r_pred;
        n_in_bit    = r_in_bit;
        n_actual    = r_actual;
        n_hist      = r_hist;
        n_out_valid = r_out_valid;
        n_out_bit   = r_out_bit;
        w_we        = 1'b0;
        w_waddr     = r_wa;
        w_wdata     = r_actual ? {w_inc, w_c0} : {w_c1, w_inc};

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                n_clr   = r_clr + PW'(1);
                if (r_clr == PW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_in_bit = i_in.in_bit;
                    n_pred   = 1'b0;
                    n_k      = '0;
                    n_rv     = 1'b0;
                    n_state  = S_PRED;
                end
            end
            S_PRED: begin
                n_rv = w_issue;
                if (w_issue) begin
                    n_k = r_k + KW'(1);
                end
                // ascending orders: a later order with data overrides
                if (r_rv && (w_c0 != '0 || w_c1 != '0)) begin
                    n_pred = (w_c1 > w_c0);
                end
                if (!w_issue && r_rv) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_bit   = r_in_bit ^ r_pred;
                    n_actual    = i_cfg.decode_mode ? (r_in_bit ^ r_pred) : r_in_bit;
                    n_k         = '0;
                    n_rv        = 1'b0;
                    n_state     = S_UPD;
                end
            end
            S_UPD: begin
                n_rv = w_issue;
                if (w_issue) begin
                    n_k  = r_k + KW'(1);
                    n_wa = w_raddr;
                end
                if (r_rv) begin
                    w_we = 1'b1;
                end
                if (!w_issue && r_rv) begin
                    n_hist  = HW'({r_hist, r_actual});
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_rv        <= 1'b0;
            r_k         <= '0;
            r_hist      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_rv        <= n_rv;
            r_k         <= n_k;
            r_hist      <= n_hist;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wa      <= n_wa;
        r_pred    <= n_pred;
        r_in_bit  <= n_in_bit;
        r_actual  <= n_actual;
        r_out_bit <= n_out_bit;
    end

    bcbp_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

endmodule

### sv/binary_context_bit_predictor.sv
// Result: the result of an item is offered after a prediction pass over orders
//   0..top, where top = min(order_in_use, MAX_ORDER), once the output is free.
// Items: a new item is accepted only after the update pass of the last one, as the count
//   RAM's single read port visits every order twice per item.
// Reset: synchronous, active low; a clearing pass then zeroes all
//   2^(MAX_ORDER+1)-1 words of the count RAM (8191 at MAX_ORDER 12) with input ready held low.
// ----------------------------------------------------------------------------
// binary_context_bit_predictor
// PPM-style bit predictor with per-order count pairs; encodes or decodes
// one bit per item as the input bit XOR the prediction.
// ----------------------------------------------------------------------------
module binary_context_bit_predictor #(
    parameter int MAX_ORDER  = 12,
    parameter int COUNT_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bcbp_in_if.sink                      i_in,
    bcbp_out_if.source                   o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bcbp_pkg::APB_AW-1:0]  paddr,
    input  logic [bcbp_pkg::APB_DW-1:0]  pwdata,
    output logic [bcbp_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import bcbp_pkg::*;

    t_cfg w_cfg;

    bcbp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bcbp_engine #(
        .MAX_ORDER  (MAX_ORDER),
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

### sv/bcbp_checker.sv
// ----------------------------------------------------------------------------
// bcbp_checker
// Port-level checks of the predictor, bound to the top level.
// ----------------------------------------------------------------------------
module bcbp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_bit
);

    // held result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_bit))
        else $error("result bit changed while stalled");

    // one item at a time: no second accept right behind the first
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accept");

    // reset empties the output and drops input ready
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready && !i_out_valid)
        else $error("channel active after reset");

endmodule

bind binary_context_bit_predictor bcbp_checker u_bcbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_bit   (o_out.out_bit)
);

### sim/binary_context_bit_predictor_test.sv
// ----------------------------------------------------------------------------
// binary_context_bit_predictor_test
// Drives bits into the predictor under random idling and back-pressure, and
// compares every output bit against a pinned table value or a local model of
// the per-order count tables and bit history. A short table of directed items comes first, then
// phases of patterned and noisy random bits under changing configuration.
// ----------------------------------------------------------------------------
module binary_context_bit_predictor_test;
    import bcbp_pkg::*;

    localparam int MAX_ORDER     = 12;
    localparam int COUNT_BITS    = 16;
    localparam int STORE_DEPTH   = (1 << (MAX_ORDER + 2)) - 2;
    localparam int IDLE_LIMIT    = 40000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_GAP       = 12;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 50;

    typedef struct packed {
        logic [ORDER_BITS-1:0] order;
        logic                  decode;
        logic                  in_bit;
        logic                  pinned;
        logic                  out_bit;
    } t_row;

    localparam int N_ROWS = 23;

    // order, decode, in_bit, pinned, out_bit
    t_row directed_rows [N_ROWS] = '{
        '{4'd12, 1'b0, 1'b1, 1'b1, 1'b1},  // nothing learned yet: residual is the bit
        '{4'd12, 1'b0, 1'b1, 1'b0, 1'b0},
        '{4'd12, 1'b0, 1'b0, 1'b0, 1'b0},
        '{4'd12, 1'b0, 1'b1, 1'b0, 1'b0},
        '{4'd12, 1'b0, 1'b1, 1'b0, 1'b0},
        '{4'd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{4'd0,  1'b0, 1'b1, 1'b0, 1'b0},
        '{4'd0,  1'b0, 1'b1, 1'b0, 1'b0},
        '{4'd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{4'd15, 1'b1, 1'b0, 1'b0, 1'b0},  // above range acts as the top order
        '{4'd15, 1'b1, 1'b1, 1'b0, 1'b0},
        '{4'd15, 1'b1, 1'b0, 1'b0, 1'b0},
        '{4'd15, 1'b1, 1'b0, 1'b0, 1'b0},
        '{4'd13, 1'b0, 1'b1, 1'b0, 1'b0},
        '{4'd13, 1'b0, 1'b0, 1'b0, 1'b0},
        '{4'd13, 1'b0, 1'b1, 1'b0, 1'b0},
        '{4'd1,  1'b1, 1'b1, 1'b0, 1'b0},
        '{4'd1,  1'b1, 1'b0, 1'b0, 1'b0},
        '{4'd1,  1'b1, 1'b1, 1'b0, 1'b0},
        '{4'd7,  1'b0, 1'b0, 1'b0, 1'b0},
        '{4'd7,  1'b0, 1'b1, 1'b0, 1'b0},
        '{4'd12, 1'b1, 1'b0, 1'b0, 1'b0},
        '{4'd12, 1'b1, 1'b1, 1'b0, 1'b0}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    bcbp_in_if  in_ch ();
    bcbp_out_if out_ch ();

    binary_context_bit_predictor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // local copy of the count tables, history and registers
    logic [COUNT_BITS-1:0] ctx_counts [STORE_DEPTH];
    logic [MAX_ORDER-1:0]  ctx_history;
    t_cfg                  cfg_mirror;

    logic        expected_out_bits [$];
    logic [1:0]  pinned_q [$];
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;
    logic        src_gaps = 1'b1;
    logic        sink_gaps = 1'b1;
    logic        stall_request = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int top_order();
        return (cfg_mirror.order_in_use > MAX_ORDER) ? MAX_ORDER
                                                     : int'(cfg_mirror.order_in_use);
    endfunction

    function automatic int unsigned pair_addr(int k);
        int unsigned ctx;
        ctx = int'(ctx_history) & ((1 << k) - 1);
        return ((1 << (k + 1)) - 2) + (ctx << 1);
    endfunction

    // Predict from the longest order with data, then learn the actual bit.
    function automatic logic code_bit(logic in_bit);
        int unsigned a;
        logic        guess;
        logic        actual;
        guess = 1'b0;
        for (int k = top_order(); k >= 0; k--) begin
            a = pair_addr(k);
            if (ctx_counts[a] != '0 || ctx_counts[a + 1] != '0) begin
                guess = ctx_counts[a + 1] > ctx_counts[a];
                break;
            end
        end
        actual = cfg_mirror.decode_mode ? (in_bit ^ guess) : in_bit;
        for (int k = 0; k <= top_order(); k++) begin
            a = pair_addr(k) + actual;
            if (ctx_counts[a] != '1) ctx_counts[a] = ctx_counts[a] + 1'b1;
        end
        ctx_history = {ctx_history[MAX_ORDER-2:0], actual};
        return in_bit ^ guess;
    endfunction

    always @(posedge i_clk) begin
        logic [1:0] pin;
        logic       want;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            pin  = pinned_q.pop_front();
            want = code_bit(in_ch.in_bit);
            expected_out_bits.push_back(pin[1] ? pin[0] : want);
        end
    end

    always @(posedge i_clk) begin
        logic want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_out_bits.size() == 0) begin
                $error("out_bit: expected nothing, got %0b", out_ch.out_bit);
                mismatch_count++;
            end else begin
                want = expected_out_bits.pop_front();
                if (out_ch.out_bit !== want) begin
                    $error("out_bit: expected %0b, got %0b", want, out_ch.out_bit);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("binary_context_bit_predictor: mismatch");
                $finish;
            end
        end
    end

    // result side: random hold before each item when gaps are on, one long hold on request
    initial begin
        int unsigned hold;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            hold = sink_gaps ? $urandom_range(0, MAX_GAP) : 0;
            if (stall_request) begin
                hold = LONG_HOLD;
                stall_request = 1'b0;
            end
            if (hold != 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    task automatic apb_cycle(input logic wr, input t_reg_idx idx,
                             input logic [APB_DW-1:0] wdata,
                             output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_back(input t_reg_idx idx, input logic [APB_DW-1:0] want);
        logic [APB_DW-1:0] rd;
        apb_cycle(1'b0, idx, '0, rd);
        if (rd !== want) begin
            $error("register %0d: expected %0h, got %0h", idx, want, rd);
            mismatch_count++;
        end
    endtask

    // Upper data bits are random; only the register's own bits must stick.
    task automatic set_config(input logic [ORDER_BITS-1:0] order, input logic decode);
        logic [APB_DW-1:0] wd;
        logic [APB_DW-1:0] rd;
        wd = $urandom();
        wd[ORDER_BITS-1:0] = order;
        apb_cycle(1'b1, REG_ORDER_IN_USE, wd, rd);
        cfg_mirror.order_in_use = order;
        wd = $urandom();
        wd[0] = decode;
        apb_cycle(1'b1, REG_DECODE_MODE, wd, rd);
        cfg_mirror.decode_mode = decode;
        read_back(REG_ORDER_IN_USE, APB_DW'(cfg_mirror.order_in_use));
        read_back(REG_DECODE_MODE, APB_DW'(cfg_mirror.decode_mode));
    endtask

    task automatic send_bit(input logic b, input logic pin, input logic pin_val);
        int unsigned gap;
        gap = src_gaps ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pinned_q.push_back({pin, pin_val});
        in_ch.valid  <= 1'b1;
        in_ch.in_bit <= b;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Drop valid, wait for every result, then let the count write-back finish.
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_out_bits.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [ORDER_BITS-1:0] order;
        logic [7:0]            pattern;
        int unsigned           period;
        logic                  noisy;
        logic                  b;

        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.in_bit <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        foreach (ctx_counts[i]) ctx_counts[i] = '0;
        ctx_history = '0;
        cfg_mirror.order_in_use = ORDER_RESET;
        cfg_mirror.decode_mode  = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_back(REG_ORDER_IN_USE, APB_DW'(ORDER_RESET));
        read_back(REG_DECODE_MODE, '0);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].order != cfg_mirror.order_in_use ||
                directed_rows[r].decode != cfg_mirror.decode_mode) begin
                settle();
                set_config(directed_rows[r].order, directed_rows[r].decode);
            end
            send_bit(directed_rows[r].in_bit, directed_rows[r].pinned,
                     directed_rows[r].out_bit);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0:       order = 4'd0;
                1:       order = 4'd15;
                2:       order = 4'd12;
                default: order = ORDER_BITS'($urandom_range(0, 15));
            endcase
            set_config(order, 1'($urandom_range(0, 1)));
            src_gaps  = ($urandom_range(0, 3) != 0);
            sink_gaps = ($urandom_range(0, 3) != 0);
            if (ph == 2) stall_request = 1'b1;
            period  = $urandom_range(1, 8);
            pattern = 8'($urandom());
            noisy   = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // pause the source until the pipeline has emptied
                if (ph == 5 && i == PHASE_ITEMS / 2) settle();
                if (cfg_mirror.decode_mode)
                    b = ($urandom_range(0, 4) == 0);
                else if (noisy)
                    b = 1'($urandom_range(0, 1));
                else
                    b = pattern[i % period] ^ ($urandom_range(0, 9) == 0);
                send_bit(b, 1'b0, 1'b0);
            end
        end

        settle();
        if (mismatch_count == 0) begin
            $display("binary_context_bit_predictor: match");
        end else begin
            $display("binary_context_bit_predictor: mismatch");
        end
        $finish;
    end

endmodule
